/* rtl/core/lzsd_pkg.sv */
`timescale 1ns / 1ps

package lzsd_pkg;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  localparam logic [8:0]  FLAG_EMPTY  = 9'h001;
  localparam logic [8:0]  FLAG_MARK   = 9'h100;
  localparam logic [12:0] DIST_BASE   = 13'h1000;
  localparam logic [4:0]  RUN_BIAS    = 5'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_HIGH
  } lzsd_phase_t;

  typedef struct packed {
    logic        lit;
    logic        copy;
    logic [7:0]  lit_byte;
    logic [12:0] distance;
    logic [4:0]  run;
    logic        done;
  } lzsd_cmd_t;

  typedef struct packed {
    logic idle;
  } lzsd_status_t;

endpackage

/* rtl/core/lzsd_if.sv */
`timescale 1ns / 1ps

interface lzsd_in_if #(
  parameter int LEN_W = 24
);
  logic             valid;
  logic             ready;
  logic             kind;
  logic [LEN_W-1:0] stream_length;
  logic [7:0]       in_byte;

  modport source (output valid, kind, stream_length, in_byte, input ready);
  modport sink (input valid, kind, stream_length, in_byte, output ready);
endinterface

interface lzsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, out_byte, last_of_run, stream_done, input ready);
  modport sink (input valid, out_byte, last_of_run, stream_done, output ready);
endinterface

/* rtl/core/lzsd_parser.sv */
`timescale 1ns / 1ps

module lzsd_parser
  import lzsd_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  lzsd_in_if.sink      in_s,
  input  lzsd_status_t status,
  output lzsd_cmd_t    cmd
);

  lzsd_phase_t            phase_r, phase_nxt;
  logic [8:0]             flags_r, flags_nxt;
  logic [7:0]             tok_r, tok_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      flags_r <= FLAG_EMPTY;
      tok_r   <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      tok_r   <= tok_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign in_s.ready = status.idle;

  always_comb begin
    logic                   acc;
    logic [4:0]             run;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [LENGTH_BITS-1:0] rem_sat;
    logic [LENGTH_BITS-1:0] len;
    acc       = in_s.valid && in_s.ready;
    run       = {1'b0, in_s.in_byte[7:4]} + RUN_BIAS;
    rem_dec   = rem_r - LENGTH_BITS'(1);
    rem_sat   = (rem_r >= LENGTH_BITS'(run)) ? rem_r - LENGTH_BITS'(run) : '0;
    len       = LENGTH_BITS'(in_s.stream_length);
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    tok_nxt   = tok_r;
    rem_nxt   = rem_r;
    cmd       = '0;
    cmd.lit_byte = in_s.in_byte;
    cmd.distance = DIST_BASE - {1'b0, in_s.in_byte[3:0], tok_r};
    cmd.run   = run;
    if (acc) begin
      if (in_s.kind == KIND_START) begin
        rem_nxt   = len;
        flags_nxt = FLAG_EMPTY;
        tok_nxt   = '0;
        phase_nxt = (len != '0) ? PH_RUN : PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_RUN: begin
            priority if (flags_r == FLAG_EMPTY) begin
              flags_nxt = FLAG_MARK | {1'b0, in_s.in_byte};
            end else if (flags_r[0]) begin
              rem_nxt   = rem_dec;
              flags_nxt = {1'b0, flags_r[8:1]};
              if (rem_dec == '0) begin
                phase_nxt = PH_IDLE;
              end
              cmd.lit  = 1'b1;
              cmd.done = (rem_dec == '0);
            end else begin
              tok_nxt   = in_s.in_byte;
              phase_nxt = PH_HIGH;
            end
          end
          PH_HIGH: begin
            rem_nxt   = rem_sat;
            flags_nxt = {1'b0, flags_r[8:1]};
            phase_nxt = (rem_sat != '0) ? PH_RUN : PH_IDLE;
            cmd.copy  = 1'b1;
            cmd.done  = (rem_sat == '0);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/lzsd_copier.sv */
`timescale 1ns / 1ps

module lzsd_copier
  import lzsd_pkg::*;
#(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  lzsd_cmd_t    cmd,
  output lzsd_status_t status,
  lzsd_out_if.source   out_s
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic [7:0]    mem [WINDOW_BYTES];

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [4:0]    left_r, left_nxt;
  logic          done_hold_r, done_hold_nxt;
  logic          pend_r;
  logic          pend_last_r;
  logic          pend_done_r;
  logic [AW-1:0] wr_addr_r;
  logic [7:0]    mem_q_r;
  logic          fwd_r;
  logic [7:0]    fwd_q_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_done_r, out_done_nxt;
  logic          skid_v_r, skid_v_nxt;
  logic [7:0]    skid_byte_r;
  logic          skid_last_r;
  logic          skid_done_r;

  logic          stall;
  logic          issue;
  logic [7:0]    ret_byte;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW:0]   wp_ext;
  logic [AW:0]   dist_ext;
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] src_inc;

  assign stall    = out_valid_r && !out_s.ready;
  assign issue    = (left_r != '0) && !skid_v_r && !(pend_r && stall);
  assign ret_byte = fwd_r ? fwd_q_r : mem_q_r;
  assign wr_en    = cmd.lit || pend_r;
  assign wr_addr  = cmd.lit ? wp_r : wr_addr_r;
  assign wr_data  = cmd.lit ? cmd.lit_byte : ret_byte;
  assign wp_ext   = {1'b0, wp_r};
  assign dist_ext = (AW + 1)'(cmd.distance);
  assign wp_inc   = (wp_r == AW'(WINDOW_BYTES - 1)) ? '0 : wp_r + 1'b1;
  assign src_inc  = (src_r == AW'(WINDOW_BYTES - 1)) ? '0 : src_r + 1'b1;

  assign status.idle = (left_r == '0) && !pend_r && !skid_v_r && !stall;

  assign out_s.valid       = out_valid_r;
  assign out_s.out_byte    = out_byte_r;
  assign out_s.last_of_run = out_last_r;
  assign out_s.stream_done = out_done_r;

  always_comb begin
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    left_nxt      = left_r;
    done_hold_nxt = done_hold_r;
    if (cmd.lit) begin
      wp_nxt = wp_inc;
    end
    if (cmd.copy) begin
      left_nxt      = cmd.run;
      done_hold_nxt = cmd.done;
      if (wp_ext >= dist_ext) begin
        src_nxt = AW'(wp_ext - dist_ext);
      end else begin
        src_nxt = AW'(wp_ext + (AW + 1)'(WINDOW_BYTES) - dist_ext);
      end
    end
    if (issue) begin
      wp_nxt   = wp_inc;
      src_nxt  = src_inc;
      left_nxt = left_r - 5'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    skid_v_nxt    = skid_v_r;
    if (!stall) begin
      priority if (skid_v_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = skid_byte_r;
        out_last_nxt  = skid_last_r;
        out_done_nxt  = skid_done_r;
        skid_v_nxt    = 1'b0;
      end else if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = ret_byte;
        out_last_nxt  = pend_last_r;
        out_done_nxt  = pend_done_r;
      end else if (cmd.lit) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = cmd.lit_byte;
        out_last_nxt  = 1'b1;
        out_done_nxt  = cmd.done;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (pend_r) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      left_r      <= '0;
      done_hold_r <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      left_r      <= left_nxt;
      done_hold_r <= done_hold_nxt;
      pend_r      <= issue;
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    if (issue) begin
      wr_addr_r   <= wp_r;
      pend_last_r <= (left_r == 5'd1);
      pend_done_r <= (left_r == 5'd1) && done_hold_r;
      fwd_r       <= wr_en && (wr_addr == src_r);
      fwd_q_r     <= wr_data;
    end
    if (stall && pend_r) begin
      skid_byte_r <= ret_byte;
      skid_last_r <= pend_last_r;
      skid_done_r <= pend_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      mem_q_r <= mem[src_r];
    end
  end

endmodule

/* rtl/core/lzss_stream_decompressor.sv */
`timescale 1ns / 1ps

// LZSS decoder fed one compressed byte per input beat, with the decoded bytes leaving one per
// output beat. A start beat loads the byte count and discards any part-parsed flags or token.
// Flag bytes and the low byte of a match token give no output; a literal is written to the
// history window and presented in the cycle after its beat. A match of n bytes (3 to 18) reads
// the window once per cycle through its single read port while the output is not stalled, and
// the input is held from the token's second byte until the match is copied out. Overlapping
// matches are forwarded from the byte written in the same cycle. The window is not cleared at
// reset; a match must only refer to bytes already decoded.
module lzss_stream_decompressor
  import lzsd_pkg::*;
#(
  parameter int WINDOW_BYTES = 4096,
  parameter int LENGTH_BITS  = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  lzsd_in_if.sink    in_s,
  lzsd_out_if.source out_s
);

  lzsd_cmd_t    cmd;
  lzsd_status_t status;

  lzsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (in_s),
    .status (status),
    .cmd    (cmd)
  );

  lzsd_copier #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_copier (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .out_s  (out_s)
  );

endmodule

/* tb/lzsd_stream_monitor.sv */
`timescale 1ns / 1ps

module lzsd_stream_monitor
  import lzsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lzsd_in_if   in_mon,
  lzsd_out_if  out_mon,
  output int   errors,
  output int   pending
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } decoded_beat_t;

  decoded_beat_t decoded_q[$];

  logic [7:0]  hist [0:4095];
  logic [11:0] wr_pos;
  logic [8:0]  flags;
  lzsd_phase_t phase;
  logic [7:0]  tok_lo;
  logic [23:0] owed;

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
    errors++;
  endtask

  task automatic decode_beat(input logic kind, input logic [23:0] len, input logic [7:0] b);
    logic [15:0] token;
    logic [12:0] distance;
    logic [4:0]  run;
    logic [7:0]  v;
    int          i;
    if (kind == KIND_START) begin
      owed   = len;
      flags  = FLAG_EMPTY;
      tok_lo = 8'h00;
      phase  = (len != 0) ? PH_RUN : PH_IDLE;
    end else if (phase == PH_RUN) begin
      if (flags == FLAG_EMPTY) begin
        flags = FLAG_MARK | {1'b0, b};
      end else if (flags[0]) begin
        hist[wr_pos] = b;
        wr_pos++;
        owed--;
        flags = flags >> 1;
        if (owed == 0) begin
          phase = PH_IDLE;
        end
        decoded_q.push_back('{data: b, last: 1'b1, done: (owed == 0)});
      end else begin
        tok_lo = b;
        phase  = PH_HIGH;
      end
    end else if (phase == PH_HIGH) begin
      token    = {b, tok_lo};
      distance = DIST_BASE - {1'b0, token[11:0]};
      run      = {1'b0, token[15:12]} + RUN_BIAS;
      owed     = (owed >= run) ? owed - run : '0;
      // Bytes are copied one at a time, so a short distance repeats what this run has just written.
      for (i = 0; i < run; i++) begin
        v = hist[wr_pos - distance[11:0]];
        hist[wr_pos] = v;
        wr_pos++;
        decoded_q.push_back('{data: v, last: (i == run - 1),
                              done: (i == run - 1) && (owed == 0)});
      end
      flags = flags >> 1;
      phase = (owed != 0) ? PH_RUN : PH_IDLE;
    end
  endtask

  always @(posedge clk) begin
    decoded_beat_t want;
    if (!rst_n) begin
      wr_pos  = '0;
      flags   = FLAG_EMPTY;
      phase   = PH_IDLE;
      tok_lo  = 8'h00;
      owed    = '0;
      errors  = 0;
      pending = 0;
      decoded_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_beat(in_mon.kind, in_mon.stream_length, in_mon.in_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("output beat %02h arrived with nothing outstanding",
                                    out_mon.out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (out_mon.out_byte != want.data) begin
            report_mismatch($sformatf("out_byte: got %02h, expected %02h",
                                      out_mon.out_byte, want.data));
          end
          if (out_mon.last_of_run != want.last) begin
            report_mismatch($sformatf("last_of_run: got %0b, expected %0b",
                                      out_mon.last_of_run, want.last));
          end
          if (out_mon.stream_done != want.done) begin
            report_mismatch($sformatf("stream_done: got %0b, expected %0b",
                                      out_mon.stream_done, want.done));
          end
        end
      end
      pending = decoded_q.size();
    end
  end

endmodule

/* tb/lzss_stream_decompressor_test.sv */
`timescale 1ns / 1ps

module lzss_stream_decompressor_test;
  import lzsd_pkg::*;

  localparam int WINDOW      = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit stall_go   = 1'b0;

  // The sender's view of the parse, kept so that every match refers to bytes already decoded.
  lzsd_phase_t tx_phase   = PH_IDLE;
  logic [8:0]  tx_flags   = FLAG_EMPTY;
  logic [23:0] tx_owed    = '0;
  logic [7:0]  tx_low     = 8'h00;
  logic [7:0]  tx_high    = 8'h00;
  int          tx_written = 0;
  bit          tx_dense   = 1'b0;
  bit          dense_only = 1'b0;
  bit          far_seen   = 1'b0;
  int          beats_sent = 0;

  lzsd_in_if #(.LEN_W(24)) in_ch ();
  lzsd_out_if              out_ch ();

  lzss_stream_decompressor u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  lzsd_stream_monitor u_monitor (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (fail_count),
    .pending (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lzss_stream_decompressor verification failed");
      $finish;
    end
  end

  initial begin
    int stall_left;
    bit stall_taken;
    stall_left   = 0;
    stall_taken  = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_go && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_idle_en && $urandom_range(0, 99) < 38);
      end
    end
  end

  task automatic send_beat(input logic kind, input logic [23:0] len, input logic [7:0] b);
    logic [4:0] run;
    while (tx_idle_en && $urandom_range(0, 99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.stream_length <= len;
    in_ch.in_byte       <= b;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    if (kind == KIND_START || tx_phase != PH_IDLE) begin
      beats_sent++;
    end
    if (kind == KIND_START) begin
      tx_owed  = len;
      tx_flags = FLAG_EMPTY;
      tx_phase = (len != 0) ? PH_RUN : PH_IDLE;
    end else if (tx_phase == PH_RUN) begin
      if (tx_flags == FLAG_EMPTY) begin
        tx_flags = FLAG_MARK | {1'b0, b};
      end else if (tx_flags[0]) begin
        tx_written = (tx_written < WINDOW) ? tx_written + 1 : WINDOW;
        tx_owed--;
        tx_flags = tx_flags >> 1;
        if (tx_owed == 0) begin
          tx_phase = PH_IDLE;
        end
      end else begin
        tx_low   = b;
        tx_phase = PH_HIGH;
      end
    end else if (tx_phase == PH_HIGH) begin
      run        = {1'b0, b[7:4]} + RUN_BIAS;
      tx_written = (tx_written + run > WINDOW) ? WINDOW : tx_written + run;
      tx_owed    = (tx_owed > run) ? tx_owed - run : '0;
      if ({b[3:0], tx_low} == 12'h000) begin
        far_seen = 1'b1;
      end
      tx_flags = tx_flags >> 1;
      tx_phase = (tx_owed != 0) ? PH_RUN : PH_IDLE;
    end
  endtask

  task automatic send_random_beat();
    int          r;
    int          d;
    int          lim;
    logic [11:0] f;
    logic [3:0]  nib;
    logic [7:0]  fl;
    logic [23:0] len;
    r = $urandom_range(0, 99);
    if (tx_phase == PH_IDLE) begin
      if (r < 8) begin
        send_beat(KIND_DATA, 24'($urandom), 8'($urandom));
      end else begin
        if (r < 14) begin
          len = '0;
        end else if (r < 20) begin
          len = 24'($urandom);
        end else if (r < 23) begin
          len = 24'hFFFFFF;
        end else begin
          tx_dense = dense_only || ($urandom_range(0, 99) < 40);
          if (tx_dense) begin
            len = 24'($urandom_range(200, 1000));
          end else if ($urandom_range(0, 99) < 40) begin
            len = 24'($urandom_range(1, 40));
          end else begin
            len = 24'($urandom_range(40, 400));
          end
        end
        send_beat(KIND_START, len, 8'($urandom));
      end
    end else if (r < 3) begin
      send_beat(KIND_START, 24'($urandom_range(1, 300)), 8'($urandom));
    end else if (tx_phase == PH_HIGH) begin
      send_beat(KIND_DATA, 24'($urandom), tx_high);
    end else if (tx_flags == FLAG_EMPTY) begin
      r = $urandom_range(0, 99);
      if (tx_dense) begin
        fl = (r < 80) ? 8'h00 : 8'($urandom);
      end else begin
        fl = (r < 30) ? 8'h00 : (r < 50) ? 8'hFF : 8'($urandom);
      end
      if (tx_written == 0) begin
        fl[0] = 1'b1;
      end
      send_beat(KIND_DATA, 24'($urandom), fl);
    end else if (tx_flags[0]) begin
      send_beat(KIND_DATA, 24'($urandom), 8'($urandom));
    end else begin
      lim = tx_written;
      r   = $urandom_range(0, 99);
      if (r < 15) begin
        d = lim;
      end else if (r < 35) begin
        d = 1;
      end else begin
        d = $urandom_range(1, (lim < 40) ? lim : 40);
      end
      r = $urandom_range(0, 99);
      if (r < (tx_dense ? 70 : 35)) begin
        nib = 4'hF;
      end else if (r < (tx_dense ? 75 : 45)) begin
        nib = 4'h0;
      end else begin
        nib = 4'($urandom);
      end
      f       = 12'(WINDOW - d);
      tx_high = {nib, f[11:8]};
      send_beat(KIND_DATA, 24'($urandom), f[7:0]);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_count != 0);
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_START;
    in_ch.stream_length = '0;
    in_ch.in_byte       = 8'h00;
    rst_n               = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A data beat and an empty stream while idle give nothing.
    send_beat(KIND_DATA, 24'($urandom), 8'hA5);
    send_beat(KIND_START, 24'h000000, 8'($urandom));
    send_beat(KIND_DATA, 24'($urandom), 8'h3C);
    // Two literals, then a distance-one match of 18 that ends the stream exactly.
    send_beat(KIND_START, 24'd20, 8'($urandom));
    send_beat(KIND_DATA, 24'($urandom), 8'hF3);
    send_beat(KIND_DATA, 24'($urandom), 8'h00);
    send_beat(KIND_DATA, 24'($urandom), 8'hFF);
    send_beat(KIND_DATA, 24'($urandom), 8'hFF);
    send_beat(KIND_DATA, 24'($urandom), 8'hFF);
    // A stream that ends on the third of its eight flags, so that the following byte is ignored.
    send_beat(KIND_START, 24'd3, 8'($urandom));
    send_beat(KIND_DATA, 24'($urandom), 8'h07);
    send_beat(KIND_DATA, 24'($urandom), 8'h80);
    send_beat(KIND_DATA, 24'($urandom), 8'h01);
    send_beat(KIND_DATA, 24'($urandom), 8'h7F);
    send_beat(KIND_DATA, 24'($urandom), 8'h55);
    // The longest stream, a short match, then a start that abandons a half-received token.
    send_beat(KIND_START, 24'hFFFFFF, 8'($urandom));
    send_beat(KIND_DATA, 24'($urandom), 8'h00);
    send_beat(KIND_DATA, 24'($urandom), 8'hFE);
    send_beat(KIND_DATA, 24'($urandom), 8'h0F);
    send_beat(KIND_DATA, 24'($urandom), 8'h00);
    // A match of 18 reaching back to the first byte overruns a stream of five.
    send_beat(KIND_START, 24'd5, 8'hFF);
    send_beat(KIND_DATA, 24'($urandom), 8'h00);
    send_beat(KIND_DATA, 24'($urandom), 8'hE6);
    send_beat(KIND_DATA, 24'($urandom), 8'hFF);

    repeat (90) send_random_beat();
    stall_go = 1'b1;
    repeat (90) send_random_beat();
    wait_drained();

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    dense_only = 1'b1;
    repeat (200) send_random_beat();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    dense_only = 1'b0;
    while ((beats_sent < 360 || !far_seen) && beats_sent < 1500) begin
      send_random_beat();
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("lzss_stream_decompressor verification clean");
    end else begin
      $display("lzss_stream_decompressor verification failed");
    end
    $finish;
  end

endmodule
